// File: hw/rtl/shp_pkg.sv
// ----------------------------------------------------------------------------
// shp_pkg
// Shared types and constants of the syslog header parser: byte classes,
// queue word layout, field tags, status codes and parser phases.
// ----------------------------------------------------------------------------
package shp_pkg;

    localparam int DATE_LENGTH = 15;
    localparam int MAX_LENGTH  = 1024;
    localparam int POS_W       = 11;
    localparam int PRI_W       = 10;
    localparam int DCNT_W      = 5;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [POS_W-1:0]  POS_LIMIT = POS_W'(MAX_LENGTH);
    localparam logic [POS_W-1:0]  POS_SAT   = {POS_W{1'b1}};
    localparam logic [DCNT_W-1:0] DATE_LAST = DCNT_W'(DATE_LENGTH);

    localparam logic [7:0] CH_OPEN  = 8'h3C;
    localparam logic [7:0] CH_CLOSE = 8'h3E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [2:0] {
        TAG_NONE = 3'd0,
        TAG_PRI  = 3'd1,
        TAG_DATE = 3'd2,
        TAG_HOST = 3'd3,
        TAG_BODY = 3'd4
    } tag_t;

    typedef enum logic [2:0] {
        ST_RUN         = 3'd0,
        ST_OK          = 3'd1,
        ST_NO_OPEN     = 3'd2,
        ST_BAD_PRI     = 3'd3,
        ST_NO_HOST_END = 3'd4,
        ST_NO_BODY_END = 3'd5
    } status_t;

    typedef enum logic [5:0] {
        PH_IDLE = 6'b000001,
        PH_PRI  = 6'b000010,
        PH_DATE = 6'b000100,
        PH_SEP  = 6'b001000,
        PH_HOST = 6'b010000,
        PH_BODY = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic       is_open;
        logic       is_close;
        logic       is_space;
        logic       is_nul;
        logic       is_digit;
        logic [3:0] digit;
    } item_t;

endpackage

// File: hw/rtl/shp_front.sv
// ----------------------------------------------------------------------------
// shp_front
// Front end: classifies each incoming byte and packs it into a queue word.
// ----------------------------------------------------------------------------
module shp_front
(
    input  logic          [7:0] byte_in,
    input  logic                start_req,
    output shp_pkg::item_t      item
);
    import shp_pkg::*;

    logic [3:0] offset;

    assign offset = byte_in[3:0] - CH_ZERO[3:0];

    always_comb
    begin
        item.data     = byte_in;
        item.start    = start_req;
        item.is_open  = (byte_in == CH_OPEN);
        item.is_close = (byte_in == CH_CLOSE);
        item.is_space = (byte_in == CH_SPACE);
        item.is_nul   = (byte_in == CH_NUL);
        item.is_digit = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
        item.digit    = offset;
    end

endmodule

// File: hw/rtl/shp_fifo.sv
// ----------------------------------------------------------------------------
// shp_fifo
// Short queue of classified words between front end and parser.
// ----------------------------------------------------------------------------
module shp_fifo
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  shp_pkg::item_t wr_word,
    output logic           full,
    input  logic           rd_en,
    output logic           valid,
    output shp_pkg::item_t rd_word
);
    import shp_pkg::*;

    item_t             mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_wr;
    logic              do_rd;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign valid   = (count_reg != '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && valid;
    assign rd_word = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_wr && do_rd)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != QCNT_W'(QUEUE_DEPTH)) |->
        (QPTR_W'(wr_ptr_reg - rd_ptr_reg) == QPTR_W'(count_reg)))
        else $error("queue pointers disagree with count");
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (full && !rd_en) |=> (count_reg == $past(count_reg)))
        else $error("queue count moved while full and not read");
`endif

endmodule

// File: hw/rtl/shp_back.sv
// ----------------------------------------------------------------------------
// shp_back
// Back end: phase tracker that tags each word, reports the datagram end,
// and holds the result in an output register.
// ----------------------------------------------------------------------------
module shp_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  shp_pkg::item_t in_word,
    output logic           in_take,
    input  logic           pop,
    output logic           empty,
    output logic     [2:0] field_tag,
    output logic     [7:0] data_byte,
    output logic           done_res,
    output logic     [2:0] status,
    output logic     [6:0] facility,
    output logic     [2:0] severity
);
    import shp_pkg::*;

    phase_t            phase_reg;
    phase_t            phase_next;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [PRI_W-1:0]  pri_reg;
    logic [PRI_W-1:0]  pri_next;
    logic              stop_reg;
    logic              stop_next;
    logic [DCNT_W-1:0] dcnt_reg;
    logic [DCNT_W-1:0] dcnt_next;
    logic [DCNT_W-1:0] dcnt_inc;
    logic [PRI_W-1:0]  pri_acc;
    logic [POS_W-1:0]  pos_inc;

    tag_t              tag_c;
    status_t           st_c;

    logic              out_valid_reg;
    tag_t              tag_reg;
    logic [7:0]        byte_reg;
    status_t           st_reg;
    logic [6:0]        fac_reg;
    logic [2:0]        sev_reg;

    assign in_take  = in_valid && (!out_valid_reg || pop);
    assign dcnt_inc = dcnt_reg + 1'b1;
    assign pri_acc  = {pri_reg[PRI_W-4:0], 3'b000} + {pri_reg[PRI_W-2:0], 1'b0}
                    + {{(PRI_W-4){1'b0}}, in_word.digit};
    assign pos_inc  = (pos_reg != POS_SAT) ? pos_reg + 1'b1 : pos_reg;

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        pri_next   = pri_reg;
        stop_next  = stop_reg;
        dcnt_next  = dcnt_reg;
        tag_c      = TAG_NONE;
        st_c       = ST_RUN;

        if (in_word.start)
        begin
            pos_next   = POS_W'(1);
            pri_next   = '0;
            stop_next  = 1'b0;
            dcnt_next  = '0;
            phase_next = PH_PRI;
            if (!in_word.is_open)
            begin
                st_c = ST_NO_OPEN;
            end
        end
        else if (phase_reg != PH_IDLE)
        begin
            pos_next = pos_inc;
            case (phase_reg)
                PH_PRI:
                begin
                    if (pos_reg >= POS_W'(2) && in_word.is_close)
                    begin
                        phase_next = PH_DATE;
                        dcnt_next  = '0;
                    end
                    else if (pos_reg >= POS_W'(4))
                    begin
                        st_c = ST_BAD_PRI;
                    end
                    else
                    begin
                        if (!stop_reg && in_word.is_digit)
                        begin
                            pri_next = pri_acc;
                        end
                        else
                        begin
                            stop_next = 1'b1;
                        end
                        tag_c = TAG_PRI;
                    end
                end
                PH_DATE:
                begin
                    dcnt_next = dcnt_inc;
                    if (dcnt_inc >= DATE_LAST)
                    begin
                        phase_next = PH_SEP;
                    end
                    tag_c = TAG_DATE;
                end
                PH_SEP:
                begin
                    phase_next = PH_HOST;
                end
                PH_HOST:
                begin
                    if (pos_reg > POS_LIMIT)
                    begin
                        st_c = ST_NO_HOST_END;
                    end
                    else if (in_word.is_space)
                    begin
                        if (pos_reg >= POS_LIMIT)
                        begin
                            st_c = ST_NO_BODY_END;
                        end
                        else
                        begin
                            phase_next = PH_BODY;
                        end
                    end
                    else if (in_word.is_nul || pos_reg == POS_LIMIT)
                    begin
                        st_c = ST_NO_HOST_END;
                    end
                    else
                    begin
                        tag_c = TAG_HOST;
                    end
                end
                PH_BODY:
                begin
                    if (in_word.is_nul && pos_reg <= POS_LIMIT)
                    begin
                        st_c = ST_OK;
                    end
                    else if (pos_reg >= POS_LIMIT)
                    begin
                        st_c = ST_NO_BODY_END;
                    end
                    else
                    begin
                        tag_c = TAG_BODY;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        if (st_c != ST_RUN)
        begin
            phase_next = PH_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            pos_reg       <= '0;
            pri_reg       <= '0;
            stop_reg      <= 1'b0;
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                pri_reg   <= pri_next;
                stop_reg  <= stop_next;
                dcnt_reg  <= dcnt_next;
            end
            if (in_take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            tag_reg  <= tag_c;
            byte_reg <= in_word.data;
            st_reg   <= st_c;
            fac_reg  <= (st_c == ST_OK) ? pri_next[PRI_W-1:3] : 7'd0;
            sev_reg  <= (st_c == ST_OK) ? pri_next[2:0] : 3'd0;
        end
    end

    assign empty     = !out_valid_reg;
    assign field_tag = tag_reg;
    assign data_byte = byte_reg;
    assign done_res  = (st_reg != ST_RUN);
    assign status    = st_reg;
    assign facility  = fac_reg;
    assign severity  = sev_reg;

`ifndef SYNTH
    a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(phase_reg))
        else $error("phase register not one-hot");
    a_done_idles: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && st_c != ST_RUN) |=> (phase_reg == PH_IDLE))
        else $error("parser not idle after a report");
    a_prio_ok_only: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (fac_reg != 7'd0 || sev_reg != 3'd0)) |-> (st_reg == ST_OK))
        else $error("priority reported without ok status");
    a_tag_running: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && st_reg != ST_RUN) |-> (tag_reg == TAG_NONE))
        else $error("tagged byte on a report");
`endif

endmodule

// File: hw/rtl/syslog_header_parser_core.sv
// ----------------------------------------------------------------------------
// syslog_header_parser_core
// Streaming syslog header tagger: classify, queue, track phase, report.
//
//   channel  | handshake     | payload
//   ---------+---------------+----------------------------------------------
//   in       | push / full   | byte_in, start_req
//   out      | pop / empty   | field_tag, data_byte, done_res, status,
//            |               | facility, severity
//
// One word per cycle sustained while pop keeps up; every byte yields one result word.
// From push to visible result a byte passes the queue, then the output register.
// The phase tracker takes a queued word whenever the output register is free
// or being popped; the four-entry queue keeps push open while pop stalls, until it fills.
// Reset clears the queue and returns the tracker to idle; no clearing pass.
// ----------------------------------------------------------------------------
module syslog_header_parser_core
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] byte_in,
    input  logic       start_req,
    output logic       empty,
    input  logic       pop,
    output logic [2:0] field_tag,
    output logic [7:0] data_byte,
    output logic       done_res,
    output logic [2:0] status,
    output logic [6:0] facility,
    output logic [2:0] severity
);
    import shp_pkg::*;

    item_t front_word;
    item_t queue_word;
    logic  queue_valid;
    logic  queue_take;

    shp_front u_front
    (
        .byte_in   (byte_in),
        .start_req (start_req),
        .item      (front_word)
    );

    shp_fifo u_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_word (front_word),
        .full    (full),
        .rd_en   (queue_take),
        .valid   (queue_valid),
        .rd_word (queue_word)
    );

    shp_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (queue_valid),
        .in_word   (queue_word),
        .in_take   (queue_take),
        .pop       (pop),
        .empty     (empty),
        .field_tag (field_tag),
        .data_byte (data_byte),
        .done_res  (done_res),
        .status    (status),
        .facility  (facility),
        .severity  (severity)
    );

endmodule
